// ===== hdl/smi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smi_pkg
// Types and constants shared by the Sellmeier index and slope block.
// ----------------------------------------------------------------------------
package smi_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_NEG    = 2'd1;
  localparam status_t ST_DOMAIN = 2'd2;
  localparam status_t ST_SAT    = 2'd3;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_B_ONE   = 3'd0;
  localparam reg_idx_t REG_B_TWO   = 3'd1;
  localparam reg_idx_t REG_B_THREE = 3'd2;
  localparam reg_idx_t REG_C_ONE   = 3'd3;
  localparam reg_idx_t REG_C_TWO   = 3'd4;
  localparam reg_idx_t REG_C_THREE = 3'd5;

  localparam logic [31:0] B_ONE_RST   = 32'd19141863;
  localparam logic [31:0] B_TWO_RST   = 32'd2432716;
  localparam logic [31:0] B_THREE_RST = 32'd628651991;
  localparam logic [47:0] C_ONE_RST   = 48'd29847681;
  localparam logic [47:0] C_TWO_RST   = 48'd133390707;
  localparam logic [47:0] C_THREE_RST = 48'd19483072197076;

  localparam logic [31:0]        IDX_DEFAULT   = 32'd1632087572;
  localparam logic [43:0]        L2_RECIP      = 44'd9223372036854;
  localparam logic [13:0]        L2_DEN        = 14'd15625;
  localparam logic [9:0]         THOUSAND      = 10'd1000;
  localparam logic [60:0]        TERM_CAP      = 61'h1000_0000_0000_0000;
  localparam logic signed [63:0] ONE_Q32       = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] SUM_LIMIT     = 64'sh0000_0010_0000_0000;
  localparam logic [31:0]        SLOPE_CAP_POS = 32'h7FFF_FFFF;
  localparam logic [31:0]        SLOPE_CAP_NEG = 32'h8000_0000;

  typedef struct packed {
    logic        vld;
    logic        neg;
    logic        pole;
    logic        magz;
    logic        domain;
    logic        big;
    logic        isat;
    logic        ssat;
    logic [31:0] nq;
  } fin_t;

endpackage
`default_nettype wire

// ===== hdl/smi_delay.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smi_delay
// Fixed-depth shift line that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
module smi_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        pipe[i] <= '0;
      end
    end else begin
      pipe[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        pipe[i] <= pipe[i-1];
      end
    end
  end

  assign q = pipe[DEPTH-1];

endmodule
`default_nettype wire

// ===== hdl/smi_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smi_mul
// Two-stage multiplier: operand a split into a low 32-bit and a high part.
// ----------------------------------------------------------------------------
module smi_mul #(
  parameter int AW = 48,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int HW = AW - 32;

  logic [31+BW:0]   plo;
  logic [HW+BW-1:0] phi;

  always_ff @(posedge clk) begin
    plo <= (32+BW)'(a[31:0]) * (32+BW)'(b);
    phi <= (HW+BW)'(a[AW-1:32]) * (HW+BW)'(b);
    p   <= {phi, 32'd0} + (AW+BW)'(plo);
  end

endmodule
`default_nettype wire

// ===== hdl/smi_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smi_div
// Pipelined restoring divider, one quotient bit per stage, with a flag for
// a quotient that does not fit in QW bits.
// ----------------------------------------------------------------------------
module smi_div #(
  parameter int NW = 64,
  parameter int DW = 20,
  parameter int QW = 44
) (
  input  logic          clk,
  input  logic [NW-1:0] x,
  input  logic [DW-1:0] d,
  output logic [QW-1:0] q,
  output logic          ovf
);

  localparam int TW = NW - QW;
  localparam int CW = (TW > DW) ? TW : DW;

  logic [DW-1:0] rem [0:QW-1];
  logic [QW-1:0] lo  [0:QW-1];
  logic [DW-1:0] dd  [0:QW-1];
  logic [QW-1:0] qv  [1:QW];
  logic          ov  [0:QW];

  // quotient fits when the upper part is below the divisor
  always_ff @(posedge clk) begin
    ov[0]  <= CW'(x[NW-1:QW]) >= CW'(d);
    rem[0] <= DW'(x[NW-1:QW]);
    lo[0]  <= x[QW-1:0];
    dd[0]  <= d;
  end

  for (genvar i = 1; i <= QW; i++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    always_comb begin
      trial = {rem[i-1], lo[i-1][QW-1]};
      diff  = trial - {1'b0, dd[i-1]};
      ge    = trial >= {1'b0, dd[i-1]};
    end

    always_ff @(posedge clk) begin
      ov[i] <= ov[i-1];
    end

    if (i == 1) begin : g_first
      always_ff @(posedge clk) begin
        qv[i] <= QW'(ge);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        qv[i] <= {qv[i-1][QW-2:0], ge};
      end
    end

    if (i < QW) begin : g_carry
      always_ff @(posedge clk) begin
        rem[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        lo[i]  <= lo[i-1] << 1;
        dd[i]  <= dd[i-1];
      end
    end
  end

  assign q   = qv[QW];
  assign ovf = ov[QW];

endmodule
`default_nettype wire

// ===== hdl/smi_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smi_sqrt
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module smi_sqrt (
  input  logic        clk,
  input  logic [63:0] x,
  output logic [31:0] r
);

  logic [33:0] rm [0:30];
  logic [31:0] rt [0:31];
  logic [63:0] xs [0:30];

  for (genvar i = 0; i < 32; i++) begin : g_step
    logic [33:0] prem;
    logic [31:0] proot;
    logic [63:0] px;
    logic [33:0] nrem;
    logic [33:0] trial;
    logic        ge;

    if (i == 0) begin : g_first
      assign prem  = '0;
      assign proot = '0;
      assign px    = x;
    end else begin : g_next
      assign prem  = rm[i-1];
      assign proot = rt[i-1];
      assign px    = xs[i-1];
    end

    always_comb begin
      nrem  = {prem[31:0], px[63:62]};
      trial = {proot, 2'b01};
      ge    = nrem >= trial;
    end

    always_ff @(posedge clk) begin
      rt[i] <= {proot[30:0], ge};
    end

    if (i < 31) begin : g_carry
      always_ff @(posedge clk) begin
        rm[i] <= ge ? nrem - trial : nrem;
        xs[i] <= px << 2;
      end
    end
  end

  assign r = rt[31];

endmodule
`default_nettype wire

// ===== hdl/sellmeier_index_and_slope.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sellmeier_index_and_slope
// Three-term Sellmeier refractive index and its slope per nanometre.
//
// channel  | ports                                      | transfer at edge
// command  | start, busy, wavelength                    | start high, busy low
// result   | done, index_value, index_slope, status     | done high, one cycle
// config   | psel, penable, pwrite, paddr, pwdata,      | psel, penable, pwrite
//          | prdata, pready                             | and pready high
//
// one item enters every cycle; busy stays low
// each result passes through a chain of bit-per-stage dividers and the
// square root, and results leave in the order of their start transfers
// rst clears the valid pipeline and reloads the coefficient registers
// the pipeline never stalls: done is shown for exactly one cycle
// ----------------------------------------------------------------------------
module sellmeier_index_and_slope (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] wavelength,
  output logic               done,
  output logic [31:0]        index_value,
  output logic signed [31:0] index_slope,
  output smi_pkg::status_t   status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  import smi_pkg::*;

  localparam int QW_T   = 61;
  localparam int QW_Q1  = 64;
  localparam int QW_Q2  = 61;
  localparam int QW_F   = 32;
  localparam int LAT_MUL = 2;
  localparam int LAT_SQ  = 32;
  localparam int LAT_L2  = LAT_MUL + 3;
  localparam int LAT_T   = QW_T + 1;
  localparam int LAT_Q1  = QW_Q1 + 1;
  localparam int LAT_Q2  = QW_Q2 + 1;
  localparam int LAT_F   = QW_F + 1;

  localparam int OFF_T   = LAT_MUL + LAT_T;
  localparam int OFF_SUM = OFF_T + 1;
  localparam int OFF_I   = OFF_SUM + LAT_SQ;
  localparam int OFF_Q1  = LAT_MUL + LAT_Q1;
  localparam int OFF_Q2  = OFF_Q1 + LAT_MUL + LAT_Q2;

  localparam int D_PRE   = 1 + LAT_L2;
  localparam int D_DNEG  = OFF_T;
  localparam int D_MAG   = OFF_Q1;
  localparam int D_DK    = OFF_Q1 + LAT_MUL;
  localparam int D_Q1SAT = LAT_MUL + LAT_Q2;
  localparam int D_ROOT  = OFF_Q2 - OFF_I;
  localparam int D_IFLAG = OFF_Q2 - OFF_SUM;
  localparam int D_CTRL  = OFF_Q2;

  // coefficient registers
  logic [31:0] b_one, b_two, b_three;
  logic [47:0] c_one, c_two, c_three;
  logic        wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_one   <= B_ONE_RST;
      b_two   <= B_TWO_RST;
      b_three <= B_THREE_RST;
      c_one   <= C_ONE_RST;
      c_two   <= C_TWO_RST;
      c_three <= C_THREE_RST;
    end else if (wr_en) begin
      unique case (paddr[5:3])
        REG_B_ONE:   b_one   <= pwdata[31:0];
        REG_B_TWO:   b_two   <= pwdata[31:0];
        REG_B_THREE: b_three <= pwdata[31:0];
        REG_C_ONE:   c_one   <= pwdata[47:0];
        REG_C_TWO:   c_two   <= pwdata[47:0];
        REG_C_THREE: c_three <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_B_ONE:   prdata = 64'(b_one);
      REG_B_TWO:   prdata = 64'(b_two);
      REG_B_THREE: prdata = 64'(b_three);
      REG_C_ONE:   prdata = 64'(c_one);
      REG_C_TWO:   prdata = 64'(c_two);
      REG_C_THREE: prdata = 64'(c_three);
      default:     prdata = '0;
    endcase
  end

  logic [2:0][31:0] bsel;
  logic [2:0][47:0] csel;

  assign bsel = {b_three, b_two, b_one};
  assign csel = {c_three, c_two, c_one};

  // input stage and wavelength squared
  logic        vld1, neg1;
  logic [23:0] mag1;
  logic [47:0] sq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    neg1 <= wavelength[23];
    mag1 <= wavelength[23] ? 24'(-wavelength) : 24'(wavelength);
    sq2  <= 48'(mag1) * 48'(mag1);
  end

  // squared wavelength scaled by reciprocal, then one correction step
  logic [43:0] l2q;
  logic [25:0] pre_q;
  logic [79:0] l2p_lo;
  logic [59:0] l2p_hi;
  logic [47:0] sq6;
  logic [43:0] l2e, l2e_r;
  logic [57:0] l2m;

  smi_mul #(.AW(48), .BW(32)) u_mul_l2lo (
    .clk (clk),
    .a   (sq2),
    .b   (L2_RECIP[31:0]),
    .p   (l2p_lo)
  );

  smi_mul #(.AW(48), .BW(12)) u_mul_l2hi (
    .clk (clk),
    .a   (sq2),
    .b   (L2_RECIP[43:32]),
    .p   (l2p_hi)
  );

  smi_delay #(.W(48), .DEPTH(LAT_MUL + 2)) u_dly_sq (
    .clk (clk),
    .rst (rst),
    .d   (sq2),
    .q   (sq6)
  );

  always_ff @(posedge clk) begin
    l2e   <= 44'(({l2p_hi, 32'd0} + 92'(l2p_lo)) >> 47);
    l2m   <= 58'(l2e) * 58'(L2_DEN);
    l2e_r <= l2e;
    l2q   <= (({sq6, 10'd0} - l2m) >= 58'(L2_DEN)) ? l2e_r + 44'd1 : l2e_r;
  end

  smi_delay #(.W(26), .DEPTH(D_PRE)) u_dly_pre (
    .clk (clk),
    .rst (rst),
    .d   ({vld1, neg1, mag1}),
    .q   (pre_q)
  );

  // distance from each resonance
  logic [2:0]       dneg_c;
  logic [2:0][47:0] dmag_c;
  logic             dvld, neg_r, pole_r, magz_r;
  logic [23:0]      mag_r;
  logic [43:0]      l2_r;
  logic [2:0]       dneg_r;
  logic [2:0][47:0] dmag_r;
  logic [2:0][57:0] dk_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dneg_c[i] = csel[i] > 48'(l2q);
      dmag_c[i] = dneg_c[i] ? csel[i] - 48'(l2q) : 48'(l2q) - csel[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld <= 1'b0;
    end else begin
      dvld <= pre_q[25];
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= pre_q[24];
    mag_r  <= pre_q[23:0];
    magz_r <= pre_q[23:0] == 24'd0;
    l2_r   <= l2q;
    dneg_r <= dneg_c;
    pole_r <= (dmag_c[0] == 48'd0) || (dmag_c[1] == 48'd0) || (dmag_c[2] == 48'd0);
    for (int i = 0; i < 3; i++) begin
      dmag_r[i] <= dmag_c[i];
      dk_r[i]   <= 58'(dmag_c[i]) * 58'(THOUSAND);
    end
  end

  logic [2:0]       dneg_t;
  logic [23:0]      mag_q1;
  logic [2:0][60:0] tval;
  logic [2:0]       tsat;
  logic [2:0][60:0] q2v;
  logic [2:0]       q2sat;
  logic [2:0]       q1ov;
  logic [2:0]       q1sat_d;

  smi_delay #(.W(3), .DEPTH(D_DNEG)) u_dly_dneg (
    .clk (clk),
    .rst (rst),
    .d   (dneg_r),
    .q   (dneg_t)
  );

  smi_delay #(.W(24), .DEPTH(D_MAG)) u_dly_mag (
    .clk (clk),
    .rst (rst),
    .d   (mag_r),
    .q   (mag_q1)
  );

  smi_delay #(.W(3), .DEPTH(D_Q1SAT)) u_dly_q1sat (
    .clk (clk),
    .rst (rst),
    .d   (q1ov),
    .q   (q1sat_d)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [47:0] dm2;
    logic [75:0] pt;
    logic [60:0] tq;
    logic        tov;
    logic [79:0] pc;
    logic [63:0] q1q;
    logic [63:0] q1;
    logic [87:0] pq;
    logic [57:0] dkq;
    logic [60:0] q2q;
    logic        q2ov;

    smi_delay #(.W(48), .DEPTH(LAT_MUL)) u_dly_dmag (
      .clk (clk),
      .rst (rst),
      .d   (dmag_r[i]),
      .q   (dm2)
    );

    // index term
    smi_mul #(.AW(44), .BW(32)) u_mul_t (
      .clk (clk),
      .a   (l2_r),
      .b   (bsel[i]),
      .p   (pt)
    );

    smi_div #(.NW(84), .DW(48), .QW(QW_T)) u_div_t (
      .clk (clk),
      .x   ({pt, 8'd0}),
      .d   (dm2),
      .q   (tq),
      .ovf (tov)
    );

    assign tsat[i] = tov || (tq > TERM_CAP);
    assign tval[i] = tsat[i] ? TERM_CAP : tq;

    // slope term, first quotient
    smi_mul #(.AW(48), .BW(32)) u_mul_c (
      .clk (clk),
      .a   (csel[i]),
      .b   (bsel[i]),
      .p   (pc)
    );

    smi_div #(.NW(104), .DW(48), .QW(QW_Q1)) u_div_q1 (
      .clk (clk),
      .x   ({pc, 24'd0}),
      .d   (dm2),
      .q   (q1q),
      .ovf (q1ov[i])
    );

    assign q1 = q1ov[i] ? '1 : q1q;

    // slope term, second quotient
    smi_mul #(.AW(64), .BW(24)) u_mul_q (
      .clk (clk),
      .a   (q1),
      .b   (mag_q1),
      .p   (pq)
    );

    smi_delay #(.W(58), .DEPTH(D_DK)) u_dly_dk (
      .clk (clk),
      .rst (rst),
      .d   (dk_r[i]),
      .q   (dkq)
    );

    smi_div #(.NW(104), .DW(58), .QW(QW_Q2)) u_div_q2 (
      .clk (clk),
      .x   ({pq, 16'd0}),
      .d   (dkq),
      .q   (q2q),
      .ovf (q2ov)
    );

    assign q2sat[i] = q2ov || (q2q > TERM_CAP);
    assign q2v[i]   = q2sat[i] ? TERM_CAP : q2q;
  end

  // index sum and square root
  logic signed [63:0] sum_c, sum_r;
  logic               isat_r;
  logic [31:0]        root;
  logic [31:0]        root_d;
  logic [2:0]         iflag_d;

  always_comb begin
    sum_c = ONE_Q32;
    for (int i = 0; i < 3; i++) begin
      if (dneg_t[i]) begin
        sum_c = sum_c - $signed(64'(tval[i]));
      end else begin
        sum_c = sum_c + $signed(64'(tval[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r  <= sum_c;
    isat_r <= |tsat;
  end

  smi_sqrt u_sqrt (
    .clk (clk),
    .x   ({sum_r[35:0], 28'd0}),
    .r   (root)
  );

  smi_delay #(.W(3), .DEPTH(D_IFLAG)) u_dly_iflag (
    .clk (clk),
    .rst (rst),
    .d   ({sum_r <= 64'sd0, sum_r >= SUM_LIMIT, isat_r}),
    .q   (iflag_d)
  );

  smi_delay #(.W(32), .DEPTH(D_ROOT)) u_dly_root (
    .clk (clk),
    .rst (rst),
    .d   (root),
    .q   (root_d)
  );

  logic [3:0] ctrl_d;

  smi_delay #(.W(4), .DEPTH(D_CTRL)) u_dly_ctrl (
    .clk (clk),
    .rst (rst),
    .d   ({dvld, neg_r, pole_r, magz_r}),
    .q   (ctrl_d)
  );

  // slope sum and index selection
  logic [31:0] nq_c;
  logic [61:0] s40_r;
  logic [41:0] nqk_r;
  fin_t        fin_r, fin_q;

  assign nq_c = ctrl_d[2] ? IDX_DEFAULT : (iflag_d[1] ? '1 : root_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_r.vld <= 1'b0;
    end else begin
      fin_r.vld <= ctrl_d[3];
    end
    s40_r        <= 62'(q2v[0]) + 62'(q2v[1]) + 62'(q2v[2]);
    nqk_r        <= 42'(nq_c) * 42'(THOUSAND);
    fin_r.neg    <= ctrl_d[2];
    fin_r.pole   <= ctrl_d[1];
    fin_r.magz   <= ctrl_d[0];
    fin_r.domain <= iflag_d[2];
    fin_r.big    <= iflag_d[1];
    fin_r.isat   <= iflag_d[0];
    fin_r.ssat   <= (|q2sat) || (|q1sat_d);
    fin_r.nq     <= nq_c;
  end

  logic [31:0] fq;
  logic        fov;

  smi_div #(.NW(92), .DW(42), .QW(QW_F)) u_div_f (
    .clk (clk),
    .x   ({s40_r, 30'd0}),
    .d   (nqk_r),
    .q   (fq),
    .ovf (fov)
  );

  smi_delay #(.W($bits(fin_t)), .DEPTH(LAT_F)) u_dly_fin (
    .clk (clk),
    .rst (rst),
    .d   (fin_r),
    .q   (fin_q)
  );

  // result stage
  logic [31:0] fcap, fmag, fslope;
  logic        fsat, fdom, fany;
  status_t     status_c;

  always_comb begin
    fcap   = fin_q.neg ? SLOPE_CAP_POS : SLOPE_CAP_NEG;
    fsat   = fov || (fq > fcap);
    fmag   = fsat ? fcap : fq;
    fslope = fin_q.neg ? fmag : 32'd0 - fmag;
    fdom   = fin_q.pole || (!fin_q.neg && fin_q.domain);
    fany   = fsat || (!fin_q.neg && (fin_q.isat || fin_q.big)) ||
             (!fin_q.magz && fin_q.ssat);
    priority if (fdom) begin
      status_c = ST_DOMAIN;
    end else if (fany) begin
      status_c = ST_SAT;
    end else if (fin_q.neg) begin
      status_c = ST_NEG;
    end else begin
      status_c = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin_q.vld;
    end
  end

  always_ff @(posedge clk) begin
    index_value <= fdom ? 32'd0 : fin_q.nq;
    index_slope <= fdom ? 32'sd0 : $signed(fslope);
    status      <= status_c;
  end

endmodule
`default_nettype wire

// ===== hdl/smi_check.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smi_check
// Port-level checks on results of the Sellmeier index and slope block.
// ----------------------------------------------------------------------------
module smi_check (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [31:0]        index_value,
  input logic signed [31:0] index_slope,
  input smi_pkg::status_t   status
);

  import smi_pkg::*;

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result transfer right after reset");

  a_domain_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_DOMAIN) |-> (index_value == 32'd0) && (index_slope == 32'sd0))
    else $error("pole or domain result carries nonzero fields");

  a_neg_index: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_NEG) |-> (index_value == IDX_DEFAULT) && !index_slope[31])
    else $error("negative wavelength result has wrong index or slope sign");

  a_ok_slope: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_OK) |-> index_slope[31] || (index_slope == 32'sd0))
    else $error("positive wavelength result has positive slope");

  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("command refused");

endmodule

bind sellmeier_index_and_slope smi_check u_smi_check (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .index_value (index_value),
  .index_slope (index_slope),
  .status      (status)
);
`default_nettype wire

// ===== sim/smi_checker.sv =====
// ----------------------------------------------------------------------------
// smi_checker
// Watches the command, result and configuration channels of the Sellmeier
// index and slope block. It keeps its own copy of the coefficients and
// predicts each result. Each result is compared field by field, in order,
// with the oldest prediction.
// ----------------------------------------------------------------------------
module smi_checker
  import smi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [23:0] wavelength,
  input  logic               done,
  input  logic [31:0]        index_value,
  input  logic signed [31:0] index_slope,
  input  status_t            status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  input  logic               pready,
  output int                 pending,
  output int                 errors
);

  typedef struct packed {
    logic [31:0] index;
    logic [31:0] slope;
    status_t     st;
  } optic_t;

  logic [31:0] coef_b [3];
  logic [47:0] coef_c [3];
  optic_t awaited_optics [$];

  assign pending = awaited_optics.size();

  function automatic logic [63:0] cap_term(input logic [127:0] x, input logic [63:0] cap,
                                           inout logic sat);
    if (x > {64'd0, cap}) begin
      sat = 1'b1;
      return cap;
    end
    return x[63:0];
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitpos;
    res = 64'd0;
    bitpos = 64'd1 << 62;
    while (bitpos > x) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (x >= res + bitpos) begin
        x = x - (res + bitpos);
        res = (res >> 1) + bitpos;
      end else begin
        res = res >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return res;
  endfunction

  function automatic optic_t sellmeier_predict(input logic signed [23:0] w);
    optic_t r;
    logic neg, sat;
    logic [63:0] mag, l2, nq, s40, q1, m, t;
    logic [63:0] dmag [3];
    logic dneg [3];
    logic signed [63:0] sum;
    neg = w[23];
    sat = 1'b0;
    mag = neg ? 64'(-(65'(signed'(w)))) : 64'(w);
    l2 = (mag * mag * 64'd65536) / 64'd1000000;
    for (int i = 0; i < 3; i++) begin
      dneg[i] = 64'(coef_c[i]) > l2;
      dmag[i] = dneg[i] ? 64'(coef_c[i]) - l2 : l2 - 64'(coef_c[i]);
      if (dmag[i] == 0) begin
        r.index = 32'd0;
        r.slope = 32'd0;
        r.st = ST_DOMAIN;
        return r;
      end
    end
    if (neg) begin
      nq = 64'(IDX_DEFAULT);
    end else begin
      sum = ONE_Q32;
      for (int i = 0; i < 3; i++) begin
        t = cap_term(((128'(coef_b[i]) * 128'(l2)) << 8) / 128'(dmag[i]),
                     64'(TERM_CAP), sat);
        sum = dneg[i] ? sum - signed'(t) : sum + signed'(t);
      end
      if (sum <= 0) begin
        r.index = 32'd0;
        r.slope = 32'd0;
        r.st = ST_DOMAIN;
        return r;
      end
      if (sum >= SUM_LIMIT) begin
        nq = 64'hFFFF_FFFF;
        sat = 1'b1;
      end else begin
        nq = root_floor(64'(sum) << 28);
      end
    end
    s40 = 64'd0;
    if (mag != 0) begin
      for (int i = 0; i < 3; i++) begin
        q1 = cap_term(((128'(coef_b[i]) * 128'(coef_c[i])) << 24) / 128'(dmag[i]),
                      64'hFFFF_FFFF_FFFF_FFFF, sat);
        s40 = s40 + cap_term(((128'(q1) * 128'(mag)) << 16) / (128'(dmag[i]) * 128'(THOUSAND)),
                             64'(TERM_CAP), sat);
      end
    end
    m = cap_term((128'(s40) << 30) / (128'(nq) * 128'(THOUSAND)),
                 neg ? 64'(SLOPE_CAP_POS) : 64'(SLOPE_CAP_NEG), sat);
    r.index = nq[31:0];
    r.slope = neg ? m[31:0] : 32'(-m);
    r.st = sat ? ST_SAT : (neg ? ST_NEG : ST_OK);
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    optic_t e;
    if (rst) begin
      coef_b[0] <= B_ONE_RST;
      coef_b[1] <= B_TWO_RST;
      coef_b[2] <= B_THREE_RST;
      coef_c[0] <= C_ONE_RST;
      coef_c[1] <= C_TWO_RST;
      coef_c[2] <= C_THREE_RST;
      awaited_optics.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[5:3]))
          REG_B_ONE:   coef_b[0] <= pwdata[31:0];
          REG_B_TWO:   coef_b[1] <= pwdata[31:0];
          REG_B_THREE: coef_b[2] <= pwdata[31:0];
          REG_C_ONE:   coef_c[0] <= pwdata[47:0];
          REG_C_TWO:   coef_c[1] <= pwdata[47:0];
          REG_C_THREE: coef_c[2] <= pwdata[47:0];
          default: ;
        endcase
      end
      if (start && !busy) awaited_optics.push_back(sellmeier_predict(wavelength));
      if (done) begin
        if (awaited_optics.size() == 0) begin
          report("unexpected transfer", 32'd0, 32'd0);
        end else begin
          e = awaited_optics.pop_front();
          if (index_value !== e.index) report("index_value", index_value, e.index);
          if (index_slope !== e.slope) report("index_slope", index_slope, e.slope);
          if (status !== e.st) report("status", 32'(status), 32'(e.st));
        end
      end
    end
  end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench top for the Sellmeier index and slope block. Writes coefficient
// sets over the register port while idle, sends directed and random
// wavelengths with random gaps, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb;
  import smi_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [23:0] wavelength = '0;
  logic done;
  logic [31:0] index_value;
  logic signed [31:0] index_slope;
  status_t status;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  int pending;
  int errors;
  logic calm;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sellmeier_index_and_slope uut (.*);

  smi_checker chk (.*);

  function automatic logic [47:0] l2_of(input int unsigned nm256);
    return 48'((64'(nm256) * 64'(nm256) * 64'd65536) / 64'd1000000);
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_coefs(input logic [31:0] b1, b2, b3, input logic [47:0] c1, c2, c3);
    write_reg(REG_B_ONE, 64'(b1));
    write_reg(REG_B_TWO, 64'(b2));
    write_reg(REG_B_THREE, 64'(b3));
    write_reg(REG_C_ONE, 64'(c1));
    write_reg(REG_C_TWO, 64'(c2));
    write_reg(REG_C_THREE, 64'(c3));
  endtask

  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_wavelength(input logic signed [23:0] w);
    int gap;
    start <= 1'b1;
    wavelength <= w;
    do @(posedge clk); while (busy);
    gap = 0;
    if (!calm) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: gap = 0;
        6, 7, 8: gap = $urandom_range(1, 3);
        default: gap = $urandom_range(10, 40);
      endcase
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [23:0] pick_wavelength();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 24'($urandom_range(300 * 256, 2500 * 256));
      6: return -24'($urandom_range(300 * 256, 2500 * 256));
      7: return 24'($urandom);
      default: return 24'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [31:0] pick_b();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, 1 << 30);
    endcase
  endfunction

  function automatic logic [47:0] pick_c(input logic signed [23:0] near);
    case ($urandom_range(0, 6))
      0: return 48'd0;
      1: return 48'hFFFF_FFFF_FFFF;
      2: return {16'($urandom), 32'($urandom)};
      3: return l2_of(near[23] ? 32'(-near) : 32'(near));
      4: return l2_of(near[23] ? 32'(-near) : 32'(near)) + 48'($urandom_range(1, 8));
      default: return 48'($urandom_range(0, 32'hFFFF_FFFF)) << $urandom_range(0, 8);
    endcase
  endfunction

  initial begin
    #3_200_000;
    $display("[sellmeier_index_and_slope] ERROR");
    $finish;
  end

  initial begin
    logic signed [23:0] probe;
    int phase_items;
    calm = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset coefficients: field extremes and negative default
    send_wavelength(24'sd0);
    send_wavelength(24'sd1);
    send_wavelength(24'sh7FFFFF);
    send_wavelength(-24'sh800000);
    send_wavelength(-24'sd1);
    send_wavelength(24'sd150000);
    send_wavelength(-24'sd150000);
    send_wavelength(24'sd21);
    send_wavelength(24'sd5000);
    send_wavelength(24'h555555);
    send_wavelength(24'hAAAAAA);
    drain();

    // pole on the first term, both signs
    write_reg(REG_C_ONE, 64'(l2_of(150000)));
    send_wavelength(24'sd150000);
    send_wavelength(-24'sd150000);
    send_wavelength(24'sd150001);
    drain();

    // strongest coefficients, zero resonances: pole at zero, saturation
    load_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'd0, 48'd0, 48'd0);
    send_wavelength(24'sd0);
    send_wavelength(24'sd1);
    send_wavelength(24'sh7FFFFF);
    send_wavelength(-24'sd1000);
    drain();

    // strong term below its resonance drives the root argument negative
    load_coefs(32'hFFFF_FFFF, 32'd0, 32'd0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
               48'hFFFF_FFFF_FFFF);
    send_wavelength(24'sh7FFFFF);
    send_wavelength(24'sd200000);
    send_wavelength(-24'sd200000);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      probe = pick_wavelength();
      if (phase == 11) begin
        load_coefs(B_ONE_RST, B_TWO_RST, B_THREE_RST, C_ONE_RST, C_TWO_RST, C_THREE_RST);
      end else begin
        load_coefs(pick_b(), pick_b(), pick_b(), pick_c(probe), pick_c(pick_wavelength()),
                   pick_c(pick_wavelength()));
      end
      calm = (phase % 4 == 1);
      phase_items = 95;
      for (int k = 0; k < phase_items; k++) begin
        if ($urandom_range(0, 15) == 0) send_wavelength(probe);
        else send_wavelength(pick_wavelength());
      end
      drain();
    end

    repeat (250) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[sellmeier_index_and_slope] OK");
    end else begin
      $display("[sellmeier_index_and_slope] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/smi_pkg.sv
hdl/smi_delay.sv
hdl/smi_mul.sv
hdl/smi_div.sv
hdl/smi_sqrt.sv
hdl/sellmeier_index_and_slope.sv
hdl/smi_check.sv
sim/smi_checker.sv
sim/tb.sv
